// ===== rtl/sorted_array_table_unit_macros.svh =====
// Assertion helpers for the sorted array table unit.
`ifndef SORTED_ARRAY_TABLE_UNIT_MACROS_SVH
`define SORTED_ARRAY_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SAT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sat check failed");

// Next-cycle implication, disabled while reset is low.
`define SAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sat check failed");

`endif

// ===== rtl/sat_pkg.sv =====
package sat_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 7;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_ABSENT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } cell_op_t;

  // Broadcast to every cell during the execute cycle.
  typedef struct packed {
    cell_op_t                   op;
    logic signed [VALUE_W-1:0]  value;
  } cell_ctrl_t;

endpackage

// ===== rtl/sat_cell.sv =====
module sat_cell import sat_pkg::*; (
  input  logic                      clk,
  input  logic                      cmp_en,
  input  logic                      occ,
  input  logic                      tail,
  input  logic signed [VALUE_W-1:0] cmp_value,
  input  cell_ctrl_t                ctrl,
  input  logic signed [VALUE_W-1:0] left_entry,
  input  logic                      left_ins,
  input  logic signed [VALUE_W-1:0] right_entry,
  output logic signed [VALUE_W-1:0] entry,
  output logic                      ins,
  output logic                      eq
);

  logic signed [VALUE_W-1:0] entry_r;
  logic                      ge_r;
  logic                      eq_r;
  logic                      tail_r;

  // compare flags, taken on the transfer cycle
  always_ff @(posedge clk) begin
    if (cmp_en) begin
      ge_r   <= occ && (entry_r >= cmp_value);
      eq_r   <= occ && (entry_r == cmp_value);
      tail_r <= tail;
    end
  end

  // insert span runs from the first entry >= value up to the tail slot
  assign ins = ge_r | tail_r;

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_INSERT: begin
        if (ins) begin
          entry_r <= left_ins ? left_entry : ctrl.value;
        end
      end
      OP_REMOVE: begin
        if (ge_r) begin
          entry_r <= right_entry;
        end
      end
      default: begin
      end
    endcase
  end

  assign entry = entry_r;
  assign eq    = eq_r;

endmodule

// ===== rtl/sorted_array_table_unit.sv =====
// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_stall  in_cmd[1:0], in_value[31:0] (signed)
// out_     output     out_valid/out_stall  out_status[1:0], out_position[5:0],
//                                          out_entry_count[6:0]
// On a transfer the cells compare the value against their entries on the
// accepting edge; then the execute state shifts the row and loads the
// result register. The unit takes one item at a time.
// Synchronous reset (rst_n low) clears the count and the control state; the
// cell contents are not cleared and are only read below the count.
// A stalled result holds in the output register; in_stall stays high while
// an item executes or while a stalled result still waits.
module sorted_array_table_unit import sat_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_cmd,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_status,
  output logic [POS_W-1:0]          out_position,
  output logic [COUNT_W-1:0]        out_entry_count
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // one-hot sequencer: wait for a transfer, then execute
  typedef enum logic [1:0] {
    FSM_IDLE = 2'b01,
    FSM_EXEC = 2'b10
  } fsm_t;

  fsm_t                      state_r, state_nxt;
  cmd_t                      cmd_r;
  logic signed [VALUE_W-1:0] value_r;
  logic [CNT_W-1:0]          count_r, count_nxt;

  logic                      out_valid_r;
  status_t                   status_r, status_nxt;
  logic [POS_W-1:0]          pos_r, pos_nxt;
  logic [COUNT_W-1:0]        cnt_out_r;

  logic signed [VALUE_W-1:0] cell_entry [CAPACITY];
  logic signed [VALUE_W-1:0] left_entry [CAPACITY];
  logic signed [VALUE_W-1:0] right_entry [CAPACITY];
  logic [CAPACITY-1:0]       ins_vec;
  logic [CAPACITY-1:0]       left_ins;
  logic [CAPACITY-1:0]       eq_vec;
  logic [CAPACITY-1:0]       occ_vec;
  logic [CAPACITY-1:0]       tail_vec;
  logic [CAPACITY-1:0]       first_vec;
  logic [IDX_W-1:0]          loc;

  logic                      accept;
  logic                      exec;
  logic                      full;
  logic                      empty;
  logic                      found;
  cell_ctrl_t                ctrl;

  assign in_stall = (state_r != FSM_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign exec     = (state_r == FSM_EXEC);
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign empty    = (count_r == '0);
  assign found    = |eq_vec;

  // per-slot occupancy and tail marker, relative to the current count
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      occ_vec[i]  = (CNT_W'(i) < count_r);
      tail_vec[i] = (CNT_W'(i) == count_r);
    end
  end

  // the row of cells; each talks only to its two neighbours
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign left_entry[g] = cell_entry[g];
      assign left_ins[g]   = 1'b0;
    end else begin : g_body
      assign left_entry[g] = cell_entry[g-1];
      assign left_ins[g]   = ins_vec[g-1];
    end
    if (g == CAPACITY - 1) begin : g_end
      assign right_entry[g] = cell_entry[g];
    end else begin : g_mid
      assign right_entry[g] = cell_entry[g+1];
    end

    sat_cell u_cell (
      .clk         (clk),
      .cmp_en      (accept),
      .occ         (occ_vec[g]),
      .tail        (tail_vec[g]),
      .cmp_value   (in_value),
      .ctrl        (ctrl),
      .left_entry  (left_entry[g]),
      .left_ins    (left_ins[g]),
      .right_entry (right_entry[g]),
      .entry       (cell_entry[g]),
      .ins         (ins_vec[g]),
      .eq          (eq_vec[g])
    );
  end

  // First slot of the insert span: the first entry >= value, else the tail.
  // That is also the first equal entry when one exists.
  assign first_vec = ins_vec & ~left_ins;

  always_comb begin
    loc = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      loc = loc | (first_vec[i] ? IDX_W'(i) : '0);
    end
  end

  always_comb begin
    ctrl.value = value_r;
    ctrl.op    = OP_HOLD;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    pos_nxt    = '0;
    case (cmd_r)
      CMD_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ctrl.op   = exec ? OP_INSERT : OP_HOLD;
          count_nxt = count_r + CNT_W'(1);
          pos_nxt   = POS_W'(loc);
        end
      end
      CMD_REMOVE: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (!found) begin
          status_nxt = ST_ABSENT;
        end else begin
          ctrl.op   = exec ? OP_REMOVE : OP_HOLD;
          count_nxt = count_r - CNT_W'(1);
          pos_nxt   = POS_W'(loc);
        end
      end
      CMD_SEARCH: begin
        if (!found) begin
          status_nxt = ST_ABSENT;
        end else begin
          pos_nxt = POS_W'(loc);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (state_r)
      FSM_IDLE: state_nxt = accept ? FSM_EXEC : FSM_IDLE;
      FSM_EXEC: state_nxt = FSM_IDLE;
      default:  state_nxt = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (exec) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= cmd_t'(in_cmd);
      value_r <= in_value;
    end
    if (exec) begin
      status_r  <= status_nxt;
      pos_r     <= pos_nxt;
      cnt_out_r <= COUNT_W'(count_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_position    = pos_r;
  assign out_entry_count = cnt_out_r;

endmodule

// ===== rtl/sat_checker.sv =====
`include "sorted_array_table_unit_macros.svh"

module sat_checker import sat_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [1:0]                out_status,
  input logic [POS_W-1:0]          out_position
);

  logic in_xfer;
  assign in_xfer = in_valid && !in_stall;

  // a stalled result stays put
  `SAT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                   out_valid && $stable(out_status) && $stable(out_position))

  // one item at a time: busy right after a transfer
  `SAT_ASSERT_NEXT(a_busy_after_xfer, clk, rst_n, in_xfer, in_stall)

  // the result shows once the execute state has loaded the result register
  `SAT_ASSERT_NEXT(a_result_latency, clk, rst_n, in_xfer, ##1 out_valid)

  // error results carry position zero
  `SAT_ASSERT_NOW(a_err_pos_zero, clk, rst_n,
                  out_valid && (out_status != ST_OK), out_position == '0)

endmodule

bind sorted_array_table_unit sat_checker u_sat_checker (.*);

// ===== tb/tb_sorted_array_table_unit.sv =====
`timescale 1ns / 100ps

// Testbench for the sorted array table unit.
// Directed rows first, then random fill / drain / mixed phases, each result
// checked against its typed-in result or a shadow copy of the table kept in the testbench.
module tb_sorted_array_table_unit;
  import sat_pkg::*;

  localparam int CAPACITY   = 64;
  localparam int IDLE_LIMIT = 2000;  // cycles with no transfer on either side
  // the last phase may run on past this number of random commands
  localparam int RANDOM_CMDS = 720;

  // One result as the unit should report it.
  typedef struct packed {
    status_t              status;
    logic [POS_W-1:0]     position;
    logic [COUNT_W-1:0]   entry_count;
  } outcome_t;

  // Directed row: typed_in set means the expected result is given here,
  // otherwise the shadow table works it out.
  typedef struct {
    cmd_t                       cmd;
    logic signed [VALUE_W-1:0]  value;
    bit                         typed_in;
    outcome_t                   want;
  } stim_row_t;

  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [1:0]                 in_cmd = CMD_INSERT;
  logic signed [VALUE_W-1:0]  in_value = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [1:0]                 out_status;
  logic [POS_W-1:0]           out_position;
  logic [COUNT_W-1:0]         out_entry_count;

  sorted_array_table_unit #(.CAPACITY(CAPACITY)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_position    (out_position),
    .out_entry_count (out_entry_count)
  );

  // Shadow of the unit's table: ascending values, first shadow_count valid.
  logic signed [VALUE_W-1:0] shadow [CAPACITY];
  int                        shadow_count = 0;

  // Results still owed by the unit, oldest first.
  outcome_t pending_outcomes [$];

  int mismatches    = 0;
  int results_seen  = 0;
  int cmds_sent     = 0;
  int peak_count    = 0;
  int status_hits [4] = '{0, 0, 0, 0};
  int idle_cycles   = 0;
  int burst_left    = 1;

  // Directed rows: empty-table refusals, the unused code, extreme values,
  // duplicates (insert goes before an equal entry; remove/search hit the first).
  stim_row_t directed_rows [22] = '{
    '{CMD_SEARCH, 32'sd0,            1'b1, '{ST_ABSENT, 6'd0, 7'd0}},
    '{CMD_REMOVE, 32'sd5,            1'b1, '{ST_EMPTY,  6'd0, 7'd0}},
    '{CMD_NOP,    32'sd7,            1'b1, '{ST_OK,     6'd0, 7'd0}},
    '{CMD_INSERT, 32'sd0,            1'b1, '{ST_OK,     6'd0, 7'd1}},
    '{CMD_INSERT, 32'sh7FFF_FFFF,    1'b1, '{ST_OK,     6'd1, 7'd2}},
    '{CMD_INSERT, 32'sh8000_0000,    1'b1, '{ST_OK,     6'd0, 7'd3}},
    '{CMD_INSERT, -32'sd1,           1'b0, '{ST_OK,     6'd0, 7'd0}},
    '{CMD_INSERT, 32'sd0,            1'b0, '{ST_OK,     6'd0, 7'd0}},
    '{CMD_SEARCH, 32'sd0,            1'b0, '{ST_OK,     6'd0, 7'd0}},
    '{CMD_SEARCH, 32'sh7FFF_FFFF,    1'b0, '{ST_OK,     6'd0, 7'd0}},
    '{CMD_SEARCH, 32'sh8000_0000,    1'b0, '{ST_OK,     6'd0, 7'd0}},
    '{CMD_SEARCH, 32'sd1,            1'b1, '{ST_ABSENT, 6'd0, 7'd5}},
    '{CMD_REMOVE, 32'sd42,           1'b1, '{ST_ABSENT, 6'd0, 7'd5}},
    '{CMD_REMOVE, 32'sd0,            1'b0, '{ST_OK,     6'd0, 7'd0}},
    '{CMD_SEARCH, 32'sd0,            1'b0, '{ST_OK,     6'd0, 7'd0}},
    '{CMD_NOP,    32'sh8000_0000,    1'b1, '{ST_OK,     6'd0, 7'd4}},
    '{CMD_INSERT, 32'sh5555_5555,    1'b0, '{ST_OK,     6'd0, 7'd0}},
    '{CMD_INSERT, 32'shAAAA_AAAA,    1'b0, '{ST_OK,     6'd0, 7'd0}},
    '{CMD_REMOVE, 32'sh8000_0000,    1'b0, '{ST_OK,     6'd0, 7'd0}},
    '{CMD_REMOVE, 32'sh7FFF_FFFF,    1'b0, '{ST_OK,     6'd0, 7'd0}},
    '{CMD_REMOVE, -32'sd1,           1'b0, '{ST_OK,     6'd0, 7'd0}},
    '{CMD_SEARCH, 32'shAAAA_AAAA,    1'b0, '{ST_OK,     6'd0, 7'd0}}
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Applies one command to the shadow table and returns what the unit
  // should answer.
  function automatic outcome_t apply_to_shadow(cmd_t c, logic signed [VALUE_W-1:0] v);
    outcome_t o;
    int       loc;
    o = '{ST_OK, '0, '0};
    case (c)
      CMD_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          o.status = ST_FULL;
        end else begin
          loc = shadow_count;
          for (int i = 0; i < shadow_count; i++) begin
            if (shadow[i] >= v) begin
              loc = i;
              break;
            end
          end
          for (int i = shadow_count; i > loc; i--) shadow[i] = shadow[i-1];
          shadow[loc] = v;
          shadow_count++;
          o.position = loc[POS_W-1:0];
        end
      end
      CMD_REMOVE, CMD_SEARCH: begin
        loc = shadow_count;
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow[i] == v) begin
            loc = i;
            break;
          end
        end
        if (c == CMD_REMOVE && shadow_count == 0) begin
          o.status = ST_EMPTY;
        end else if (loc >= shadow_count) begin
          o.status = ST_ABSENT;
        end else begin
          if (c == CMD_REMOVE) begin
            for (int i = loc; i + 1 < shadow_count; i++) shadow[i] = shadow[i+1];
            shadow_count--;
          end
          o.position = loc[POS_W-1:0];
        end
      end
      default: ;  // unused code: no change, status ok
    endcase
    o.entry_count = shadow_count[COUNT_W-1:0];
    return o;
  endfunction

  // Small values so that duplicates and hits are common, plus held
  // values, the extremes and full 32-bit noise.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 35) return int'($urandom_range(0, 16)) - 8;
    if (sel < 50 && shadow_count > 0) return shadow[$urandom_range(0, shadow_count - 1)];
    if (sel < 60) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh7FFF_FFFF;
        1:       return 32'sh8000_0000;
        2:       return '0;
        default: return '1;
      endcase
    end
    return $urandom();
  endfunction

  // Presents one command and holds it until the transfer. The shadow table
  // is updated at the accepting edge, so the next pick sees the new contents.
  // Valid stays high across a burst; at the end of a burst it drops for a
  // random gap.
  task automatic issue(input cmd_t c, input logic signed [VALUE_W-1:0] v,
                       input bit typed_in, input outcome_t want);
    outcome_t o;
    in_valid <= 1'b1;
    in_cmd   <= c;
    in_value <= v;
    do @(posedge clk); while (in_stall);
    o = apply_to_shadow(c, v);
    pending_outcomes.push_back(typed_in ? want : o);
    cmds_sent++;
    if (shadow_count > peak_count) peak_count = shadow_count;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      // a quarter of the bursts are long stretches with no gaps
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 6);
    end
  endtask

  task automatic issue_random(input cmd_t c, input logic signed [VALUE_W-1:0] v);
    issue(c, v, 1'b0, '{ST_OK, '0, '0});
  endtask

  // Fill towards a target, with some searches and removes mixed in; when the
  // target is the full table a few inserts are refused afterwards.
  task automatic fill_phase(input int target);
    int unsigned sel;
    while (shadow_count < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 80)      issue_random(CMD_INSERT, pick_value());
      else if (sel < 95) issue_random(CMD_SEARCH, pick_value());
      else               issue_random(CMD_REMOVE, pick_value());
    end
    if (target == CAPACITY) begin
      repeat ($urandom_range(1, 3)) issue_random(CMD_INSERT, pick_value());
    end
  endtask

  // Drain to a floor, mostly removing held values; at zero the empty-table
  // refusals get exercised.
  task automatic drain_phase(input int floor_count);
    int unsigned sel;
    while (shadow_count > floor_count) begin
      sel = $urandom_range(0, 99);
      if (sel < 75)      issue_random(CMD_REMOVE,
                                      shadow[$urandom_range(0, shadow_count - 1)]);
      else if (sel < 85) issue_random(CMD_REMOVE, pick_value());
      else if (sel < 95) issue_random(CMD_SEARCH, pick_value());
      else               issue_random(CMD_INSERT, pick_value());
    end
    if (floor_count == 0) begin
      issue_random(CMD_REMOVE, pick_value());
      issue_random(CMD_SEARCH, pick_value());
    end
  endtask

  // Result side: stalls on a pattern that changes mode every so often -
  // never, scattered single cycles, or long runs on and off.
  initial begin : stall_pattern
    int mode;
    int run;
    bit level;
    level = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      run  = 0;
      repeat ($urandom_range(40, 160)) begin
        @(posedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 2) == 0);
          default: begin
            if (run == 0) begin
              level = !level;
              run   = $urandom_range(1, 12);
            end
            run--;
            out_stall <= level;
          end
        endcase
      end
    end
  end

  // Every result transfer is checked against the oldest owed result.
  always @(posedge clk) begin : result_check
    outcome_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_outcomes.size() == 0) begin
        $error("result with nothing owed: status %0d position %0d count %0d",
               out_status, out_position, out_entry_count);
        mismatches++;
      end else begin
        want = pending_outcomes.pop_front();
        status_hits[want.status]++;
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          mismatches++;
        end
        if (out_position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, out_position);
          mismatches++;
        end
        if (out_entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count,
                 out_entry_count);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither channel completes a transfer.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else                                                      idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    wait (idle_cycles >= IDLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int random_start;
    // Reset held low from the start, released at a clock edge.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows.
    foreach (directed_rows[i]) begin
      issue(directed_rows[i].cmd, directed_rows[i].value, directed_rows[i].typed_in,
            directed_rows[i].want);
    end

    // Random phases: full fill/drain cycles dominate, with partial swings
    // and stretches of arbitrary commands (unused code included) between.
    random_start = cmds_sent;
    while (cmds_sent - random_start < RANDOM_CMDS) begin
      case ($urandom_range(0, 3))
        0, 1: begin
          fill_phase(CAPACITY);
          drain_phase(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 20));
        end
        2: begin
          fill_phase($urandom_range(shadow_count, CAPACITY));
          drain_phase($urandom_range(0, shadow_count));
        end
        default: begin
          repeat ($urandom_range(10, 40))
            issue_random(cmd_t'($urandom_range(0, 3)), pick_value());
        end
      endcase
    end
    in_valid <= 1'b0;

    // Drain owed results, then give the unit a few cycles to show anything
    // spurious. The watchdog bounds the wait.
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Ran %0d commands, checked %0d results, peak occupancy %0d of %0d.",
             cmds_sent, results_seen, peak_count, CAPACITY);
    $display("Statuses seen: ok %0d, full %0d, empty %0d, not found %0d.",
             status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_EMPTY],
             status_hits[ST_ABSENT]);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sat_pkg.sv
rtl/sat_cell.sv
rtl/sorted_array_table_unit.sv
rtl/sat_checker.sv
tb/tb_sorted_array_table_unit.sv
